// ===== rtl/adc_ratiometric_averager_macros.svh =====
// ----------------------------------------------------------------------------
// ADC averager assertion macros
// Shared property wrappers for the averager checker, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ADC_RATIOMETRIC_AVERAGER_MACROS_SVH
`define ADC_RATIOMETRIC_AVERAGER_MACROS_SVH

// Checked only while reset is released.
`define ADCRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ADCRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/adcra_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC averager package
// Fixed field widths, constants and item kind codes of the averager.
// ----------------------------------------------------------------------------
`default_nettype none

package adcra_pkg;

    localparam int KIND_W     = 2;
    localparam int SUPPLY_W   = 16;
    localparam int AVG_W      = 16;
    localparam int RATIO_W    = 20;
    localparam int MV_W       = 16;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 16;
    localparam int COUNT_W    = 8;
    localparam int NUM_W      = 13;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd52800;
    localparam logic [NUM_W-1:0]   RATIO_NUM   = 13'd5000;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_SAMPLE = 2'd0;
    localparam t_kind KIND_READ   = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/adc_ratiometric_averager.sv =====
// Flow: one item at a time; a new item is taken only once the previous result has
//   entered the output register. A sample with a supply value runs one division and
//   a read with samples held runs two, on the shared restoring divider (one quotient
//   bit a cycle); other items skip it. A stalled result holds the last step.
// Reset (i_rst_n low, synchronous): clear all channel state, set count_scale to 52800.
// ----------------------------------------------------------------------------
// ADC ratiometric averager
// Averaging front end for one analog channel: accumulates raw and supply
// compensated sums, latches averages on read, scales them to millivolts.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ratiometric_averager
    import adcra_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int HALVE_AT    = 254,
    parameter int FRAC_BITS   = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration: count_scale, millivolts per count, unsigned Q8.16
    input  wire logic                 i_cfg_we,
    input  wire logic [SCALE_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata, low bit up: sample, supply_mv, zero pad
    input  wire logic [((SAMPLE_BITS+SUPPLY_W+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: kind
    input  wire logic [KIND_W-1:0]    i_s_axis_tuser,
    // output stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // tdata, low bit up: latest, average, ratio_average, voltage_mv,
    // ratio_voltage_mv, latest_mv, zero pad
    output logic [((SAMPLE_BITS+AVG_W+RATIO_W+3*MV_W+7)/8)*8-1:0] o_m_axis_tdata
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int OUT_BITS = SAMPLE_BITS + AVG_W + RATIO_W + 3 * MV_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    // Ratiometric dividend: sample * 5000, shifted by the fraction bits.
    localparam int TERM_W   = SAMPLE_BITS + NUM_W + FRAC_BITS;
    // Sums hold at most (count + 1) full-scale terms, count below 256.
    localparam int PSUM_W   = SAMPLE_BITS + COUNT_W;
    localparam int RSUM_W   = RATIO_W + COUNT_W;
    // Divider width covers every dividend (the plain average one is always narrower).
    localparam int DW       = (TERM_W > RSUM_W) ? TERM_W : RSUM_W;
    localparam int BIT_W    = $clog2(DW);
    localparam int PROD_W   = RATIO_W + SCALE_W;

    // ------------------------------------------------------------------
    // Sequencer codes
    // ------------------------------------------------------------------
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_DIV_TERM = 4'd2;
    localparam logic [3:0] S_ACC      = 4'd3;
    localparam logic [3:0] S_DIV_AVG  = 4'd4;
    localparam logic [3:0] S_DIV_RAT  = 4'd5;
    localparam logic [3:0] S_MUL_A    = 4'd6;
    localparam logic [3:0] S_MUL_R    = 4'd7;
    localparam logic [3:0] S_MUL_L    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    // ------------------------------------------------------------------
    // Saturation helpers
    // ------------------------------------------------------------------
    function automatic logic [RATIO_W-1:0] sat_ratio(input logic [DW-1:0] v);
        sat_ratio = (|v[DW-1:RATIO_W]) ? {RATIO_W{1'b1}} : v[RATIO_W-1:0];
    endfunction

    function automatic logic [AVG_W-1:0] sat_avg(input logic [DW-1:0] v);
        sat_avg = (|v[DW-1:AVG_W]) ? {AVG_W{1'b1}} : v[AVG_W-1:0];
    endfunction

    function automatic logic [MV_W-1:0] sat_mv(input logic [PROD_W-1:0] v);
        sat_mv = (|v[PROD_W-1:MV_W]) ? {MV_W{1'b1}} : v[MV_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]             r_state,  n_state;
    logic [SCALE_W-1:0]     r_scale,  n_scale;
    // captured item
    t_kind                  r_kind,   n_kind;
    logic [SAMPLE_BITS-1:0] r_smp,    n_smp;
    logic [SUPPLY_W-1:0]    r_sup,    n_sup;
    // channel state
    logic [SAMPLE_BITS-1:0] r_last,   n_last;
    logic [PSUM_W-1:0]      r_psum,   n_psum;
    logic [RSUM_W-1:0]      r_rsum,   n_rsum;
    logic [COUNT_W-1:0]     r_cnt,    n_cnt;
    logic [AVG_W-1:0]       r_havg,   n_havg;
    logic [RATIO_W-1:0]     r_hrat,   n_hrat;
    // shared divider
    logic [DW-1:0]          r_quo,    n_quo;
    logic [SUPPLY_W-1:0]    r_rem,    n_rem;
    logic [SUPPLY_W-1:0]    r_dvs,    n_dvs;
    logic [BIT_W-1:0]       r_bit,    n_bit;
    logic [RATIO_W-1:0]     r_term,   n_term;
    // shared multiplier and millivolt results
    logic [PROD_W-1:0]      r_prod,   n_prod;
    logic [MV_W-1:0]        r_vmv,    n_vmv;
    logic [MV_W-1:0]        r_rvmv,   n_rvmv;
    // output register
    logic                   r_mvalid, n_mvalid;
    logic [OUT_W-1:0]       r_mdata,  n_mdata;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                   s_xfer;
    logic [SUPPLY_W:0]      div_trial;
    logic                   div_ge;
    logic [SUPPLY_W-1:0]    div_rem_nx;
    logic [DW-1:0]          div_quo_nx;
    logic                   div_last;
    logic [RATIO_W-1:0]     mul_a;
    logic [PROD_W-1:0]      prod_frac;
    logic [PROD_W-1:0]      prod_int;
    logic [RSUM_W-1:0]      acc_rsum;
    logic [COUNT_W-1:0]     acc_cnt;
    logic                   out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;
    assign out_free        = !r_mvalid || i_m_axis_tready;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign div_trial  = {r_rem, r_quo[DW-1]};
    assign div_ge     = div_trial >= {1'b0, r_dvs};
    assign div_rem_nx = div_ge ? SUPPLY_W'(div_trial - {1'b0, r_dvs})
                               : div_trial[SUPPLY_W-1:0];
    assign div_quo_nx = {r_quo[DW-2:0], div_ge};
    assign div_last   = (r_bit == '0);

    // Multiplier operand follows the sequencer step.
    always_comb begin
        case (r_state)
            S_MUL_A: mul_a = RATIO_W'(r_havg);
            S_MUL_R: mul_a = r_hrat;
            default: mul_a = RATIO_W'(r_last);
        endcase
    end

    // Averages carry FRAC_BITS extra fraction bits; the raw sample does not.
    assign prod_frac = r_prod >> (SCALE_FRAC + FRAC_BITS);
    assign prod_int  = r_prod >> SCALE_FRAC;

    assign acc_rsum = r_rsum + RSUM_W'(r_term);
    assign acc_cnt  = r_cnt + COUNT_W'(1);

    // ------------------------------------------------------------------
    // Sequencer and next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_scale  = i_cfg_we ? i_cfg_wdata : r_scale;
        n_kind   = r_kind;
        n_smp    = r_smp;
        n_sup    = r_sup;
        n_last   = r_last;
        n_psum   = r_psum;
        n_rsum   = r_rsum;
        n_cnt    = r_cnt;
        n_havg   = r_havg;
        n_hrat   = r_hrat;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_bit    = r_bit;
        n_term   = r_term;
        n_prod   = r_prod;
        n_vmv    = r_vmv;
        n_rvmv   = r_rvmv;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;

        // Drop the held result once the sink takes it.
        if (r_mvalid && i_m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Capture the item; only the low SAMPLE_BITS bits of the sample count.
                if (s_xfer) begin
                    n_kind  = i_s_axis_tuser;
                    n_smp   = i_s_axis_tdata[SAMPLE_BITS-1:0];
                    n_sup   = i_s_axis_tdata[SAMPLE_BITS +: SUPPLY_W];
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                case (r_kind)
                    KIND_SAMPLE: begin
                        n_last = r_smp;
                        n_psum = r_psum + PSUM_W'(r_smp);
                        if (r_sup == '0) begin
                            // No supply reading: use the plain count as the term.
                            n_term  = sat_ratio(DW'(r_smp) << FRAC_BITS);
                            n_state = S_ACC;
                        end else begin
                            n_quo   = DW'(TERM_W'(r_smp) * TERM_W'(RATIO_NUM)) << FRAC_BITS;
                            n_rem   = '0;
                            n_dvs   = r_sup;
                            n_bit   = BIT_W'(DW - 1);
                            n_state = S_DIV_TERM;
                        end
                    end
                    KIND_READ: begin
                        // With nothing accumulated, keep the previous averages.
                        if (r_cnt != '0) begin
                            n_quo   = DW'(r_psum) << FRAC_BITS;
                            n_rem   = '0;
                            n_dvs   = SUPPLY_W'(r_cnt);
                            n_bit   = BIT_W'(DW - 1);
                            n_state = S_DIV_AVG;
                        end else begin
                            n_state = S_MUL_A;
                        end
                    end
                    KIND_CLEAR: begin
                        n_last  = '0;
                        n_psum  = '0;
                        n_rsum  = '0;
                        n_cnt   = '0;
                        n_havg  = '0;
                        n_hrat  = '0;
                        n_state = S_MUL_A;
                    end
                    default: begin
                        n_state = S_MUL_A;
                    end
                endcase
            end

            S_DIV_TERM: begin
                n_quo = div_quo_nx;
                n_rem = div_rem_nx;
                n_bit = r_bit - BIT_W'(1);
                if (div_last) begin
                    n_term  = sat_ratio(div_quo_nx);
                    n_state = S_ACC;
                end
            end

            S_ACC: begin
                // Fold in the term and halve everything when the count hits the limit.
                if (acc_cnt >= COUNT_W'(HALVE_AT)) begin
                    n_psum = r_psum >> 1;
                    n_rsum = acc_rsum >> 1;
                    n_cnt  = acc_cnt >> 1;
                end else begin
                    n_rsum = acc_rsum;
                    n_cnt  = acc_cnt;
                end
                n_state = S_MUL_A;
            end

            S_DIV_AVG: begin
                n_quo = div_quo_nx;
                n_rem = div_rem_nx;
                n_bit = r_bit - BIT_W'(1);
                if (div_last) begin
                    // Latch the plain average, then reuse the divider for the ratio sum.
                    n_havg  = sat_avg(div_quo_nx);
                    n_quo   = DW'(r_rsum);
                    n_rem   = '0;
                    n_bit   = BIT_W'(DW - 1);
                    n_state = S_DIV_RAT;
                end
            end

            S_DIV_RAT: begin
                n_quo = div_quo_nx;
                n_rem = div_rem_nx;
                n_bit = r_bit - BIT_W'(1);
                if (div_last) begin
                    n_hrat  = sat_ratio(div_quo_nx);
                    n_psum  = '0;
                    n_rsum  = '0;
                    n_cnt   = '0;
                    n_state = S_MUL_A;
                end
            end

            S_MUL_A: begin
                n_prod  = PROD_W'(mul_a * r_scale);
                n_state = S_MUL_R;
            end

            S_MUL_R: begin
                n_vmv   = sat_mv(prod_frac);
                n_prod  = PROD_W'(mul_a * r_scale);
                n_state = S_MUL_L;
            end

            S_MUL_L: begin
                n_rvmv  = sat_mv(prod_frac);
                n_prod  = PROD_W'(mul_a * r_scale);
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hold here until the output register is free.
                if (out_free) begin
                    n_mdata  = OUT_W'({sat_mv(prod_int), r_rvmv, r_vmv,
                                       r_hrat, r_havg, r_last});
                    n_mvalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and channel state, cleared by reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scale  <= SCALE_RESET;
            r_mvalid <= 1'b0;
            r_last   <= '0;
            r_psum   <= '0;
            r_rsum   <= '0;
            r_cnt    <= '0;
            r_havg   <= '0;
            r_hrat   <= '0;
        end else begin
            r_state  <= n_state;
            r_scale  <= n_scale;
            r_mvalid <= n_mvalid;
            r_last   <= n_last;
            r_psum   <= n_psum;
            r_rsum   <= n_rsum;
            r_cnt    <= n_cnt;
            r_havg   <= n_havg;
            r_hrat   <= n_hrat;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_smp   <= n_smp;
        r_sup   <= n_sup;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_bit   <= n_bit;
        r_term  <= n_term;
        r_prod  <= n_prod;
        r_vmv   <= n_vmv;
        r_rvmv  <= n_rvmv;
        r_mdata <= n_mdata;
    end

endmodule

`default_nettype wire

// ===== rtl/adcra_checker.sv =====
// ----------------------------------------------------------------------------
// ADC averager port checker
// Watches the averager ports over time and flags handshake or result slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_ratiometric_averager_macros.svh"

module adcra_checker
    import adcra_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 i_s_axis_tready,
    input wire logic                 i_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [((SAMPLE_BITS+AVG_W+RATIO_W+3*MV_W+7)/8)*8-1:0] i_m_axis_tdata
);

    localparam int AVG_LO  = SAMPLE_BITS;
    localparam int VMV_LO  = SAMPLE_BITS + AVG_W + RATIO_W;
    localparam int LMV_LO  = VMV_LO + 2 * MV_W;

    logic in_xfer;
    logic avg_zero;
    logic last_zero;

    assign in_xfer   = i_s_axis_tvalid && i_s_axis_tready;
    assign avg_zero  = (i_m_axis_tdata[AVG_LO +: AVG_W] == '0);
    assign last_zero = (i_m_axis_tdata[SAMPLE_BITS-1:0] == '0);

    // Reset leaves the block idle with nothing to deliver.
    `ADCRA_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!i_m_axis_tvalid && i_s_axis_tready), "block not idle after reset")

    // The block is busy after each take: no transfer in back to back cycles.
    `ADCRA_ASSERT(a_busy_after_take, in_xfer |=> !i_s_axis_tready, "input taken while item in work")

    // A stalled result must not move.
    `ADCRA_ASSERT(a_out_hold, (i_m_axis_tvalid && !i_m_axis_tready) |=> (i_m_axis_tvalid && $stable(i_m_axis_tdata)), "stalled result changed")

    // Zero average and zero latest sample scale to zero millivolts.
    `ADCRA_ASSERT(a_zero_scale, (i_m_axis_tvalid && avg_zero && last_zero) |-> (i_m_axis_tdata[VMV_LO +: MV_W] == '0 && i_m_axis_tdata[LMV_LO +: MV_W] == '0), "zero input gave nonzero millivolts")

endmodule

bind adc_ratiometric_averager adcra_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_adcra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/adc_ratiometric_averager_checker.sv =====
// ----------------------------------------------------------------------------
// ADC averager scoreboard
// Watches the configuration port and both streams, keeps its own copy of the
// channel state, predicts every report and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ratiometric_averager_checker
    import adcra_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int HALVE_AT    = 254,
    parameter int FRAC_BITS   = 4,
    parameter int IN_W        = ((SAMPLE_BITS+SUPPLY_W+7)/8)*8,
    parameter int OUT_W       = ((SAMPLE_BITS+AVG_W+RATIO_W+3*MV_W+7)/8)*8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [SCALE_W-1:0] i_cfg_wdata,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [IN_W-1:0]    i_s_tdata,
    input  wire logic [KIND_W-1:0]  i_s_tuser,
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [OUT_W-1:0]   i_m_tdata,
    output int                      o_pending,
    output int                      o_fail_count
);

    localparam longint unsigned RATIO_CAP = (64'd1 << RATIO_W) - 1;
    localparam longint unsigned AVG_CAP   = (64'd1 << AVG_W) - 1;
    localparam longint unsigned MV_CAP    = (64'd1 << MV_W) - 1;

    typedef struct packed {
        logic [IN_W-SAMPLE_BITS-SUPPLY_W-1:0] pad;
        logic [SUPPLY_W-1:0]                  supply_mv;
        logic [SAMPLE_BITS-1:0]               sample;
    } t_sample_item;

    // Packed high field first, so the lowest field lands in the low bits.
    typedef struct packed {
        logic [MV_W-1:0]        latest_mv;
        logic [MV_W-1:0]        ratio_voltage_mv;
        logic [MV_W-1:0]        voltage_mv;
        logic [RATIO_W-1:0]     ratio_average;
        logic [AVG_W-1:0]       average;
        logic [SAMPLE_BITS-1:0] latest;
    } t_report;

    // Channel copy kept by the scoreboard
    logic [SCALE_W-1:0]     mv_per_count = SCALE_RESET;
    logic [SAMPLE_BITS-1:0] last_count   = '0;
    longint unsigned        plain_acc    = 0;
    longint unsigned        ratio_acc    = 0;
    int unsigned            samples_held = 0;
    logic [AVG_W-1:0]       held_avg     = '0;
    logic [RATIO_W-1:0]     held_ratio   = '0;

    t_report expected_reports[$];
    int      mismatches = 0;

    function automatic logic [MV_W-1:0] to_millivolts(input longint unsigned value,
                                                       input int unsigned shift);
        longint unsigned mv;
        mv = (value * 64'(mv_per_count)) >> shift;
        return (mv > MV_CAP) ? MV_CAP[MV_W-1:0] : mv[MV_W-1:0];
    endfunction

    // Apply one item to the channel copy and return the report it produces.
    function automatic t_report advance_channel(input t_kind kind,
                                                input logic [SAMPLE_BITS-1:0] smp,
                                                input logic [SUPPLY_W-1:0] sup);
        longint unsigned count_w;
        longint unsigned term;
        longint unsigned quot;
        t_report         rep;
        count_w = 64'(smp);
        case (kind)
            KIND_SAMPLE: begin
                last_count = smp;
                plain_acc  += count_w;
                if (sup == 0) begin
                    term = count_w << FRAC_BITS;
                end else begin
                    term = ((count_w * 64'(RATIO_NUM)) << FRAC_BITS) / 64'(sup);
                end
                if (term > RATIO_CAP) begin
                    term = RATIO_CAP;
                end
                ratio_acc += term;
                samples_held++;
                if (samples_held >= HALVE_AT) begin
                    plain_acc    >>= 1;
                    ratio_acc    >>= 1;
                    samples_held >>= 1;
                end
            end
            KIND_READ: begin
                // An empty channel keeps the averages latched earlier.
                if (samples_held != 0) begin
                    quot       = (plain_acc << FRAC_BITS) / 64'(samples_held);
                    held_avg   = (quot > AVG_CAP) ? AVG_CAP[AVG_W-1:0] : quot[AVG_W-1:0];
                    quot       = ratio_acc / 64'(samples_held);
                    held_ratio = (quot > RATIO_CAP) ? RATIO_CAP[RATIO_W-1:0]
                                                    : quot[RATIO_W-1:0];
                    plain_acc    = 0;
                    ratio_acc    = 0;
                    samples_held = 0;
                end
            end
            KIND_CLEAR: begin
                last_count   = '0;
                plain_acc    = 0;
                ratio_acc    = 0;
                samples_held = 0;
                held_avg     = '0;
                held_ratio   = '0;
            end
            default: begin
            end
        endcase
        rep.latest           = last_count;
        rep.average          = held_avg;
        rep.ratio_average    = held_ratio;
        rep.voltage_mv       = to_millivolts(64'(held_avg), SCALE_FRAC + FRAC_BITS);
        rep.ratio_voltage_mv = to_millivolts(64'(held_ratio), SCALE_FRAC + FRAC_BITS);
        rep.latest_mv        = to_millivolts(64'(last_count), SCALE_FRAC);
        return rep;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_sample_item item;
        t_report      got;
        t_report      want;
        if (!i_rst_n) begin
            mv_per_count = SCALE_RESET;
            last_count   = '0;
            plain_acc    = 0;
            ratio_acc    = 0;
            samples_held = 0;
            held_avg     = '0;
            held_ratio   = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                mv_per_count = i_cfg_wdata;
            end
            // Retire the result first: it always belongs to an earlier item.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_reports.size() == 0) begin
                    $error("result transfer with no report expected: tdata %h", i_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("latest", 64'(want.latest), 64'(got.latest));
                    compare_field("average", 64'(want.average), 64'(got.average));
                    compare_field("ratio_average", 64'(want.ratio_average),
                                  64'(got.ratio_average));
                    compare_field("voltage_mv", 64'(want.voltage_mv), 64'(got.voltage_mv));
                    compare_field("ratio_voltage_mv", 64'(want.ratio_voltage_mv),
                                  64'(got.ratio_voltage_mv));
                    compare_field("latest_mv", 64'(want.latest_mv), 64'(got.latest_mv));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                item = i_s_tdata;
                expected_reports.push_back(advance_channel(i_s_tuser, item.sample,
                                                           item.supply_mv));
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

// ===== tb/tb_adc_ratiometric_averager.sv =====
// ----------------------------------------------------------------------------
// ADC averager testbench
// Drives sample, read, clear and unused items through the averager under
// several count_scale settings, with random gaps on both streams and one
// long output stall; a scoreboard beside the block predicts every report.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adc_ratiometric_averager;
    import adcra_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int IN_W         = ((SAMPLE_BITS+SUPPLY_W+7)/8)*8;
    localparam int OUT_W        = ((SAMPLE_BITS+AVG_W+RATIO_W+3*MV_W+7)/8)*8;
    localparam int PHASE_ITEMS  = 255;
    // The output stall outlasts the longest read plus both gaps.
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int SETTLE_CYCLES = 4;

    localparam t_kind KIND_UNUSED = 2'd3;
    localparam logic [SAMPLE_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [SUPPLY_W-1:0]    SUPPLY_MAX = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [SCALE_W-1:0]     cfg_data  = '0;
    logic                   src_valid = 1'b0;
    logic [IN_W-1:0]        src_data  = '0;
    logic [KIND_W-1:0]      src_kind  = '0;
    logic                   res_ready = 1'b0;
    wire logic              src_ready;
    wire logic              res_valid;
    wire logic [OUT_W-1:0]  res_data;

    int pending;
    int fail_count;
    int items_sent   = 0;
    int idle_cycles  = 0;
    bit no_idle      = 1'b0;
    bit hold_pending = 1'b0;

    adc_ratiometric_averager DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),
        .i_s_axis_tuser  (src_kind),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    adc_ratiometric_averager_checker u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_data),
        .i_s_tvalid   (src_valid),
        .i_s_tready   (src_ready),
        .i_s_tdata    (src_data),
        .i_s_tuser    (src_kind),
        .i_m_tvalid   (res_valid),
        .i_m_tready   (res_ready),
        .i_m_tdata    (res_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // End the run with failures if neither stream nor the config port moves for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (src_valid && src_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: draw a gap before each transfer; on request hold tready low
    // for a long stretch so the block backs up and stops taking input.
    initial begin : result_sink
        int unsigned gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (gap != 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // A zero gap keeps tvalid high straight into the next transfer.
    task automatic push_item(input t_kind kind, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [SUPPLY_W-1:0] sup);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= {{(IN_W-SAMPLE_BITS-SUPPLY_W){1'b0}}, sup, smp};
        src_kind  <= kind;
        do @(posedge clk); while (!src_ready);
        items_sent++;
    endtask

    // Drop tvalid and wait for every report before returning.
    task automatic drain_reports();
        src_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write count_scale only once the channel is idle.
    task automatic write_scale(input logic [SCALE_W-1:0] value);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Favor the rails of the ADC range, otherwise uniform.
    function automatic logic [SAMPLE_BITS-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COUNT_MAX;
            default: return SAMPLE_BITS'($urandom_range(0, COUNT_MAX));
        endcase
    endfunction

    // Mix of no compensation, tiny rails (term saturates), nominal 5 V and noise.
    function automatic logic [SUPPLY_W-1:0] pick_supply();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SUPPLY_W'($urandom_range(1, 64));
            2:       return SUPPLY_MAX;
            3, 4:    return SUPPLY_W'($urandom_range(4500, 5500));
            default: return SUPPLY_W'($urandom_range(0, SUPPLY_MAX));
        endcase
    endfunction

    task automatic push_sample();
        push_item(KIND_SAMPLE, pick_count(), pick_supply());
    endtask

    // Non-sample kinds carry random payload that the block must ignore.
    task automatic push_command(input t_kind kind);
        push_item(kind, SAMPLE_BITS'($urandom_range(0, COUNT_MAX)),
                  SUPPLY_W'($urandom_range(0, SUPPLY_MAX)));
    endtask

    // Run past the halving point at least once before reading.
    task automatic fill_past_halving();
        repeat ($urandom_range(254, 300)) push_sample();
        push_command(KIND_READ);
    endtask

    task automatic random_phase(input int quota);
        int stop_at;
        int unsigned pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 5) == 0);
            pick    = $urandom_range(0, 15);
            if (pick < 11) begin
                // Typical use: a burst of samples closed by a read.
                repeat ($urandom_range(1, 24)) push_sample();
                push_command(KIND_READ);
            end else if (pick == 11) begin
                // Samples left open so the count creeps across reads' absence.
                repeat ($urandom_range(1, 40)) push_sample();
            end else if (pick == 12) begin
                push_command(KIND_CLEAR);
            end else if (pick == 13) begin
                push_command(KIND_UNUSED);
            end else begin
                push_command(KIND_READ);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, unused kind, field rails, saturation, clear.
        push_item(KIND_READ, '0, '0);
        push_item(KIND_UNUSED, COUNT_MAX, SUPPLY_MAX);
        push_item(KIND_SAMPLE, COUNT_MAX, '0);
        push_item(KIND_SAMPLE, '0, 16'd1);
        push_item(KIND_SAMPLE, COUNT_MAX, 16'd1);
        push_item(KIND_SAMPLE, COUNT_MAX, SUPPLY_MAX);
        push_item(KIND_SAMPLE, 12'd1, SUPPLY_MAX);
        push_item(KIND_SAMPLE, 12'd2048, 16'd5000);
        push_item(KIND_SAMPLE, 12'hAAA, 16'h5555);
        push_item(KIND_SAMPLE, 12'h555, 16'hAAAA);
        push_item(KIND_READ, COUNT_MAX, SUPPLY_MAX);
        push_item(KIND_READ, '0, '0);
        push_item(KIND_SAMPLE, 12'd123, 16'd4800);
        push_item(KIND_UNUSED, '0, '0);
        push_item(KIND_CLEAR, COUNT_MAX, SUPPLY_MAX);
        push_item(KIND_READ, '0, '0);
        // Saturated terms only: the ratiometric average pins at its maximum.
        repeat (4) push_item(KIND_SAMPLE, COUNT_MAX, 16'd1);
        push_item(KIND_READ, '0, '0);
        push_item(KIND_CLEAR, '0, '0);

        // Reset scale.
        random_phase(PHASE_ITEMS);

        // Zero scale: every millivolt field reads zero.
        write_scale('0);
        fill_past_halving();
        random_phase(PHASE_ITEMS - 280);

        // Full scale saturates the millivolt fields; stall the result side here.
        write_scale('1);
        hold_pending = 1'b1;
        random_phase(PHASE_ITEMS);

        // Unity gain, 1.0 mV per count.
        write_scale(24'h010000);
        fill_past_halving();
        random_phase(PHASE_ITEMS - 280);

        write_scale(SCALE_W'($urandom_range(0, (1 << SCALE_W) - 1)));
        random_phase(PHASE_ITEMS);

        // Let the last reports land, then allow for any stray output.
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
